/* rtl/mtfw_pkg.sv */
package mtfw_pkg;

   localparam int NUM_MUTEX_DEFAULT = 32;
   localparam int NUM_TASKS_DEFAULT = 64;

   localparam int REQ_W    = 2;
   localparam int ID_W     = 6;
   localparam int STATUS_W = 3;
   localparam int NEW_W    = 5;

   localparam logic [REQ_W-1:0] REQ_CREATE = 2'd0;
   localparam logic [REQ_W-1:0] REQ_LOCK   = 2'd1;
   localparam logic [REQ_W-1:0] REQ_UNLOCK = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOSPACE  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DEADLOCK = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTOWNER = 3'd4;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_LINK
   } state_type;

   // One word of the mutex table.
   typedef struct packed {
      logic            locked;
      logic            nonempty;
      logic [ID_W-1:0] holder;
      logic [ID_W-1:0] head;
      logic [ID_W-1:0] tail;
   } entry_type;

endpackage

/* rtl/mtfw_req_if.sv */
interface mtfw_req_if;
   import mtfw_pkg::*;

   logic                valid;
   logic                ready;
   logic [REQ_W-1:0]    req_type;
   logic [ID_W-1:0]     mutex_id;
   logic [ID_W-1:0]     task_id;

   modport source (output valid, input ready, output req_type, output mutex_id,
                   output task_id);
   modport sink (input valid, output ready, input req_type, input mutex_id,
                 input task_id);
endinterface

interface mtfw_rsp_if;
   import mtfw_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [NEW_W-1:0]    new_mutex;
   logic                blocked;
   logic                woken_valid;
   logic [ID_W-1:0]     woken_task;

   modport source (output valid, input ready, output status, output new_mutex,
                   output blocked, output woken_valid, output woken_task);
   modport sink (input valid, output ready, input status, input new_mutex,
                 input blocked, input woken_valid, input woken_task);
endinterface

/* rtl/mutex_table_with_fifo_waiters_core.sv */
// Mutex table with FIFO wait queues.
// Requests arrive on req_chan (create, lock, unlock with a mutex and a task id)
// and each one gives exactly one item on rsp_chan: a status, the index of a
// newly created mutex, a blocked flag for a queued lock, and the task that
// received the mutex on an unlock handoff.
// An accepted request has its entry read into a register, and its result goes
// to the output register once that is free. No new request is taken until the
// last is done; an unlock that hands the mutex on while more tasks still wait
// also passes the link state, reading the link memory after the table read.
// The mutex table and the link memory are single-port synchronous RAMs; every
// request does one table read and at most one write back.
// Mutexes are handed out in order and never freed, so a single allocation
// counter tells which entries exist. Reset clears that counter and the control
// state at once; there is no clearing pass and the memories are not reset.
// No request is taken while reset is high.
// The result sits in an output register. While the receiver stalls, the block
// still takes the next request and reads its entry, then holds it until the
// output register frees up.
module mutex_table_with_fifo_waiters_core #(
   parameter int NUM_MUTEX = mtfw_pkg::NUM_MUTEX_DEFAULT,
   parameter int NUM_TASKS = mtfw_pkg::NUM_TASKS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   mtfw_req_if.sink    req_chan,
   mtfw_rsp_if.source  rsp_chan
);
   import mtfw_pkg::*;

   localparam int MW = (NUM_MUTEX > 1) ? $clog2(NUM_MUTEX) : 1;
   localparam int TW = $clog2(NUM_TASKS);
   localparam int CW = $clog2(NUM_MUTEX + 1);

   entry_type       mutex_mem [NUM_MUTEX];
   logic [ID_W-1:0] next_mem  [NUM_TASKS];

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [REQ_W-1:0] kind_ff;
   logic [ID_W-1:0] mutex_ff;
   logic [ID_W-1:0] task_ff;
   entry_type       entry_rd_ff;
   logic [ID_W-1:0] next_rd_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [NEW_W-1:0]    new_mutex_ff, new_mutex_in;
   logic                blocked_ff, blocked_in;
   logic                woken_valid_ff, woken_valid_in;
   logic [ID_W-1:0]     woken_task_ff, woken_task_in;

   logic            accept;
   logic            rsp_load;
   logic            ent_re;
   logic            ent_we;
   entry_type       ent_wdata;
   logic            nxt_we;
   logic [TW-1:0]   nxt_waddr;
   logic            nxt_re;
   logic [MW-1:0]   rd_idx;
   logic [MW-1:0]   wr_idx;
   logic [MW-1:0]   new_idx;
   logic [TW-1:0]   head_idx;
   logic            mutex_ok;

   logic [MW+ID_W-1:0]   rd_idx_wide;
   logic [MW+ID_W-1:0]   wr_idx_wide;
   logic [TW+ID_W-1:0]   tail_wide;
   logic [TW+ID_W-1:0]   head_wide;
   logic [NEW_W+CW-1:0]  count_wide;

   assign accept = req_chan.valid && req_chan.ready;

   assign rd_idx_wide = {{MW{1'b0}}, req_chan.mutex_id};
   assign wr_idx_wide = {{MW{1'b0}}, mutex_ff};
   assign tail_wide   = {{TW{1'b0}}, entry_rd_ff.tail};
   assign head_wide   = {{TW{1'b0}}, entry_rd_ff.head};
   assign count_wide  = {{NEW_W{1'b0}}, count_ff};

   assign rd_idx   = rd_idx_wide[MW-1:0];
   assign wr_idx   = wr_idx_wide[MW-1:0];
   assign head_idx = head_wide[TW-1:0];
   assign new_idx  = count_ff[MW-1:0];

   // Entries below the allocation count exist; this also covers ids past the table.
   assign mutex_ok = 32'(mutex_ff) < 32'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_chan.req_type;
         mutex_ff <= req_chan.mutex_id;
         task_ff  <= req_chan.task_id;
      end
      if (rsp_load) begin
         status_ff      <= status_in;
         new_mutex_ff   <= new_mutex_in;
         blocked_ff     <= blocked_in;
         woken_valid_ff <= woken_valid_in;
         woken_task_ff  <= woken_task_in;
      end
   end

   // Mutex table: read on accept, written back in execute or link.
   always_ff @(posedge clock) begin
      if (ent_we) begin
         mutex_mem[(kind_ff == REQ_CREATE) ? new_idx : wr_idx] <= ent_wdata;
      end
      if (ent_re) begin
         entry_rd_ff <= mutex_mem[rd_idx];
      end
   end

   // Per-task next-waiter links.
   always_ff @(posedge clock) begin
      if (nxt_we) begin
         next_mem[nxt_waddr] <= task_ff;
      end
      if (nxt_re) begin
         next_rd_ff <= next_mem[head_idx];
      end
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      req_chan.ready = 1'b0;
      ent_re         = 1'b0;
      ent_we         = 1'b0;
      ent_wdata      = entry_rd_ff;
      nxt_we         = 1'b0;
      nxt_waddr      = tail_wide[TW-1:0];
      nxt_re         = 1'b0;
      rsp_load       = 1'b0;
      status_in      = ST_OK;
      new_mutex_in   = '0;
      blocked_in     = 1'b0;
      woken_valid_in = 1'b0;
      woken_task_in  = '0;

      case (state_ff)
         S_IDLE: begin
            req_chan.ready = !reset;
            if (req_chan.valid && !reset) begin
               ent_re   = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
               case (kind_ff)
                  REQ_CREATE: begin
                     if (32'(count_ff) < NUM_MUTEX) begin
                        ent_we       = 1'b1;
                        ent_wdata    = '0;
                        count_in     = count_ff + 1'b1;
                        new_mutex_in = count_wide[NEW_W-1:0];
                     end else begin
                        status_in = ST_NOSPACE;
                     end
                  end
                  REQ_LOCK: begin
                     if (!mutex_ok) begin
                        status_in = ST_INVALID;
                     end else if (entry_rd_ff.locked && entry_rd_ff.holder == task_ff) begin
                        status_in = ST_DEADLOCK;
                     end else if (!entry_rd_ff.locked) begin
                        ent_we             = 1'b1;
                        ent_wdata.locked   = 1'b1;
                        ent_wdata.holder   = task_ff;
                        ent_wdata.nonempty = 1'b0;
                     end else if (32'(task_ff) >= NUM_TASKS) begin
                        status_in = ST_INVALID;
                     end else begin
                        ent_we = 1'b1;
                        if (!entry_rd_ff.nonempty) begin
                           ent_wdata.head     = task_ff;
                           ent_wdata.nonempty = 1'b1;
                        end else begin
                           nxt_we = 32'(entry_rd_ff.tail) < NUM_TASKS;
                        end
                        ent_wdata.tail = task_ff;
                        blocked_in     = 1'b1;
                     end
                  end
                  REQ_UNLOCK: begin
                     if (!mutex_ok) begin
                        status_in = ST_INVALID;
                     end else if (!entry_rd_ff.locked || entry_rd_ff.holder != task_ff) begin
                        status_in = ST_NOTOWNER;
                     end else if (!entry_rd_ff.nonempty) begin
                        ent_we           = 1'b1;
                        ent_wdata.locked = 1'b0;
                        ent_wdata.holder = '0;
                     end else begin
                        woken_valid_in = 1'b1;
                        woken_task_in  = entry_rd_ff.head;
                        if (entry_rd_ff.head == entry_rd_ff.tail) begin
                           ent_we             = 1'b1;
                           ent_wdata.holder   = entry_rd_ff.head;
                           ent_wdata.nonempty = 1'b0;
                        end else begin
                           // More tasks wait: fetch the old head's link, which names the new head.
                           nxt_re   = 1'b1;
                           state_in = S_LINK;
                        end
                     end
                  end
                  default: begin
                     status_in = ST_INVALID;
                  end
               endcase
            end
         end
         S_LINK: begin
            ent_we           = 1'b1;
            ent_wdata.holder = entry_rd_ff.head;
            ent_wdata.head   = next_rd_ff;
            state_in         = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.new_mutex   = new_mutex_ff;
   assign rsp_chan.blocked     = blocked_ff;
   assign rsp_chan.woken_valid = woken_valid_ff;
   assign rsp_chan.woken_task  = woken_task_ff;

endmodule

/* rtl/mtfw_checker.sv */
module mtfw_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [mtfw_pkg::STATUS_W-1:0] rsp_status,
   input logic [mtfw_pkg::NEW_W-1:0]    rsp_new_mutex,
   input logic                          rsp_blocked,
   input logic                          rsp_woken_valid,
   input logic [mtfw_pkg::ID_W-1:0]     rsp_woken_task
);
   import mtfw_pkg::*;

   // A stalled result item keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_new_mutex) && $stable(rsp_blocked)
         && $stable(rsp_woken_valid) && $stable(rsp_woken_task))
      else $error("result item changed while stalled");

   // A refused request carries no allocation, queueing or handoff.
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_new_mutex == '0 && !rsp_blocked
         && !rsp_woken_valid && rsp_woken_task == '0)
      else $error("refused request reports side results");

   // A request cannot both queue and hand off.
   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_blocked && rsp_woken_valid))
      else $error("blocked and woken in one result item");

   // One request is processed at a time.
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken in the cycle after another");

endmodule

bind mutex_table_with_fifo_waiters_core mtfw_checker u_mtfw_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_new_mutex   (rsp_chan.new_mutex),
   .rsp_blocked     (rsp_chan.blocked),
   .rsp_woken_valid (rsp_chan.woken_valid),
   .rsp_woken_task  (rsp_chan.woken_task)
);
